>>> design/rob_pkg.sv
// ----------------------------------------------------------------------------
// rob_pkg: shared types and helpers for the raster-op blit engine
// Command record, opcode and raster function codes, combine and mask helpers.
// ----------------------------------------------------------------------------
package rob_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int COORD_W    = 13;  // holds 0..4096
  localparam int SW         = 19;  // signed clip arithmetic
  localparam int ADDR_W     = 24;  // linear address for up to 4096 x 4096
  localparam int PIX_W      = 32;
  localparam int RF_W       = 8;
  localparam int CFG_W      = 9;
  localparam int DEPTH_W    = 6;
  localparam int FIFO_DEPTH = 2;

  localparam logic [1:0] OP_FILL = 2'd0;
  localparam logic [1:0] OP_COPY = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] CFG_SURF_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SURF_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PIX_DEPTH   = 2'd2;

  localparam logic [RF_W-1:0] ROP_CLEAR    = 8'd0;
  localparam logic [RF_W-1:0] ROP_AND      = 8'd1;
  localparam logic [RF_W-1:0] ROP_AND_REV  = 8'd2;
  localparam logic [RF_W-1:0] ROP_COPY     = 8'd3;
  localparam logic [RF_W-1:0] ROP_AND_INV  = 8'd4;
  localparam logic [RF_W-1:0] ROP_NOOP     = 8'd5;
  localparam logic [RF_W-1:0] ROP_XOR      = 8'd6;
  localparam logic [RF_W-1:0] ROP_OR       = 8'd7;
  localparam logic [RF_W-1:0] ROP_NOR      = 8'd8;
  localparam logic [RF_W-1:0] ROP_EQUIV    = 8'd9;
  localparam logic [RF_W-1:0] ROP_INVERT   = 8'd10;
  localparam logic [RF_W-1:0] ROP_OR_REV   = 8'd11;
  localparam logic [RF_W-1:0] ROP_COPY_INV = 8'd12;
  localparam logic [RF_W-1:0] ROP_OR_INV   = 8'd13;
  localparam logic [RF_W-1:0] ROP_NAND     = 8'd14;
  localparam logic [RF_W-1:0] ROP_SET      = 8'd15;

  typedef struct packed {
    logic [1:0]         op;
    logic               rd_zero;
    logic               rev_x;
    logic               rev_y;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] ncols;
    logic [COORD_W-1:0] nrows;
    logic [PIX_W-1:0]   src_val;
    logic [RF_W-1:0]    rfunc;
    logic [PIX_W-1:0]   wmask;
    logic [PIX_W-1:0]   dmask;
  } cmd_t;

  function automatic logic [PIX_W-1:0] rop_apply(input logic [RF_W-1:0] f,
                                                 input logic [PIX_W-1:0] s,
                                                 input logic [PIX_W-1:0] d);
    logic [PIX_W-1:0] r;
    case (f)
      ROP_CLEAR:    r = '0;
      ROP_AND:      r = s & d;
      ROP_AND_REV:  r = s & ~d;
      ROP_COPY:     r = s;
      ROP_AND_INV:  r = ~s & d;
      ROP_NOOP:     r = d;
      ROP_XOR:      r = s ^ d;
      ROP_OR:       r = s | d;
      ROP_NOR:      r = ~(s | d);
      ROP_EQUIV:    r = ~(s ^ d);
      ROP_INVERT:   r = ~d;
      ROP_OR_REV:   r = s | ~d;
      ROP_COPY_INV: r = ~s;
      ROP_OR_INV:   r = ~s | d;
      ROP_NAND:     r = ~(s & d);
      ROP_SET:      r = '1;
      default:      r = d;
    endcase
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] bits_for_depth(input logic [DEPTH_W-1:0] depth);
    logic [PIX_W-1:0] m;
    if (depth >= DEPTH_W'(PIX_W)) begin
      m = '1;
    end else begin
      m = (PIX_W'(1) << depth) - PIX_W'(1);
    end
    return m;
  endfunction

  function automatic logic signed [SW-1:0] smax(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [SW-1:0] smin(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

>>> design/raster_op_blit_engine.sv
// ----------------------------------------------------------------------------
// raster_op_blit_engine: frame store with fill, copy and read commands
// Top level: configuration registers, intake, command queue, pixel engine.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  plain write port for surface_width, surface_height, pixel_depth;
//          write only while the engine is idle.
//   in_*   command transaction (valid/stall). Fill and copy clip to the
//          surface and combine with one of 16 raster functions under the
//          plane and depth masks; read returns one pixel on out_*.
//   out_*  read result transaction (valid/stall), one per read command.
// Flow: intake registers and clips each command, the queue holds 2 commands.
//   Fill takes a destination read and a write per clipped pixel; copy adds
//   a source read first, both reads sharing the single read port of the
//   store. Each command starts with a setup step.
// Reset: the store is cleared one word per cycle, all MAX_WIDTH*MAX_HEIGHT
//   words, with in_stall high throughout; config writes are still taken.
// A stalled result holds in its output register; the engine waits on the
//   next read, and in_stall rises once the queue and intake fill.
// ----------------------------------------------------------------------------
module raster_op_blit_engine #(
  parameter int MAX_WIDTH  = rob_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rob_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [rob_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic signed [15:0]         in_src_x,
  input  logic signed [15:0]         in_src_y,
  input  logic signed [15:0]         in_dst_x,
  input  logic signed [15:0]         in_dst_y,
  input  logic [15:0]                in_area_width,
  input  logic [15:0]                in_area_height,
  input  logic [31:0]                in_fill_value,
  input  logic [7:0]                 in_raster_function,
  input  logic [31:0]                in_plane_mask,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                out_read_data
);

  localparam int CW  = rob_pkg::COORD_W;
  localparam int CFW = rob_pkg::CFG_W;

  logic [CFW-1:0]              surf_w_r, surf_h_r;
  logic [rob_pkg::DEPTH_W-1:0] pix_depth_r;
  logic [CW-1:0]               eff_w, eff_h;
  logic [rob_pkg::PIX_W-1:0]   dmask;

  logic          push, pop, fifo_full, fifo_empty, clearing;
  rob_pkg::cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_w_r    <= CFW'(256);
      surf_h_r    <= CFW'(256);
      pix_depth_r <= rob_pkg::DEPTH_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        rob_pkg::CFG_SURF_WIDTH:  surf_w_r    <= cfg_wdata;
        rob_pkg::CFG_SURF_HEIGHT: surf_h_r    <= cfg_wdata;
        rob_pkg::CFG_PIX_DEPTH:   pix_depth_r <= cfg_wdata[rob_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // oversized surfaces are limited to the store dimensions
  assign eff_w = (CW'(surf_w_r) > CW'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : CW'(surf_w_r);
  assign eff_h = (CW'(surf_h_r) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(surf_h_r);
  assign dmask = rob_pkg::bits_for_depth(pix_depth_r);

  rob_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .eff_w              (eff_w),
    .eff_h              (eff_h),
    .dmask              (dmask),
    .clearing           (clearing),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_src_x           (in_src_x),
    .in_src_y           (in_src_y),
    .in_dst_x           (in_dst_x),
    .in_dst_y           (in_dst_y),
    .in_area_width      (in_area_width),
    .in_area_height     (in_area_height),
    .in_fill_value      (in_fill_value),
    .in_raster_function (in_raster_function),
    .in_plane_mask      (in_plane_mask),
    .fifo_full          (fifo_full),
    .push               (push),
    .push_cmd           (push_cmd)
  );

  rob_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  rob_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .eff_w         (eff_w),
    .fifo_empty    (fifo_empty),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

endmodule

>>> design/rob_front.sv
// ----------------------------------------------------------------------------
// rob_front: command intake and clipping
// Registers each transaction, clips it to the surface in two stages and pushes
// a ready-to-run command into the queue; empty and unused commands are dropped.
// ----------------------------------------------------------------------------
module rob_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [rob_pkg::COORD_W-1:0]        eff_w,
  input  logic [rob_pkg::COORD_W-1:0]        eff_h,
  input  logic [rob_pkg::PIX_W-1:0]          dmask,
  input  logic                               clearing,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_opcode,
  input  logic signed [15:0]                 in_src_x,
  input  logic signed [15:0]                 in_src_y,
  input  logic signed [15:0]                 in_dst_x,
  input  logic signed [15:0]                 in_dst_y,
  input  logic [15:0]                        in_area_width,
  input  logic [15:0]                        in_area_height,
  input  logic [31:0]                        in_fill_value,
  input  logic [7:0]                         in_raster_function,
  input  logic [31:0]                        in_plane_mask,
  input  logic                               fifo_full,
  output logic                               push,
  output rob_pkg::cmd_t                      push_cmd
);

  localparam int SW = rob_pkg::SW;
  localparam int CW = rob_pkg::COORD_W;

  // stage 1: raw transaction
  logic              s1_valid_r, s1_valid_nxt;
  logic [1:0]        s1_op_r;
  logic signed [15:0] s1_sx_r, s1_sy_r, s1_dx_r, s1_dy_r;
  logic [15:0]       s1_aw_r, s1_ah_r;
  logic [31:0]       s1_fv_r, s1_pm_r;
  logic [7:0]        s1_rf_r;

  // stage 2: clip bounds
  logic                 s2_valid_r, s2_valid_nxt;
  logic [1:0]           s2_op_r;
  logic signed [SW-1:0] s2_sx_r, s2_sy_r, s2_dx_r, s2_dy_r;
  logic signed [SW-1:0] s2_lo_x_r, s2_lo_y_r, s2_hi_x_r, s2_hi_y_r;
  logic                 s2_in_rng_r;
  logic [31:0]          s2_fv_r, s2_wmask_r;
  logic [7:0]           s2_rf_r;

  logic s2_drop, s2_done, s2_load, s1_free, in_acc;

  logic signed [SW-1:0] sx_e, sy_e, dx_e, dy_e, aw_e, ah_e, w_e, h_e;
  logic signed [SW-1:0] lo_x, lo_y, hi_x, hi_y;
  logic                 in_rng;

  logic                 empty, rev_x, rev_y;
  logic signed [SW-1:0] c0, r0;

  assign s2_drop = (s2_op_r == rob_pkg::OP_NONE) ||
                   ((s2_op_r != rob_pkg::OP_READ) && empty);
  assign s2_done = s2_valid_r && (s2_drop || !fifo_full);
  assign push    = s2_valid_r && !s2_drop && !fifo_full;
  assign s2_load = s1_valid_r && (!s2_valid_r || s2_done);
  assign s1_free = !s1_valid_r || s2_load;
  assign in_stall = !s1_free || clearing;
  assign in_acc  = in_valid && !in_stall;

  assign s1_valid_nxt = in_acc ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
  assign s2_valid_nxt = s2_load ? 1'b1 : (s2_done ? 1'b0 : s2_valid_r);

  // clip bounds from stage 1
  always_comb begin
    sx_e = SW'(s1_sx_r);
    sy_e = SW'(s1_sy_r);
    dx_e = SW'(s1_dx_r);
    dy_e = SW'(s1_dy_r);
    aw_e = signed'({{(SW-16){1'b0}}, s1_aw_r});
    ah_e = signed'({{(SW-16){1'b0}}, s1_ah_r});
    w_e  = signed'({{(SW-CW){1'b0}}, eff_w});
    h_e  = signed'({{(SW-CW){1'b0}}, eff_h});
    if (s1_op_r == rob_pkg::OP_COPY) begin
      lo_x = rob_pkg::smax(rob_pkg::smax('0, -sx_e), -dx_e);
      lo_y = rob_pkg::smax(rob_pkg::smax('0, -sy_e), -dy_e);
      hi_x = rob_pkg::smin(rob_pkg::smin(aw_e, w_e - sx_e), w_e - dx_e);
      hi_y = rob_pkg::smin(rob_pkg::smin(ah_e, h_e - sy_e), h_e - dy_e);
    end else begin
      lo_x = rob_pkg::smax(dx_e, '0);
      lo_y = rob_pkg::smax(dy_e, '0);
      hi_x = rob_pkg::smin(dx_e + aw_e, w_e);
      hi_y = rob_pkg::smin(dy_e + ah_e, h_e);
    end
    in_rng = (dx_e >= 0) && (dy_e >= 0) && (dx_e < w_e) && (dy_e < h_e);
  end

  // start corner and counts from stage 2
  always_comb begin
    empty = (s2_lo_x_r >= s2_hi_x_r) || (s2_lo_y_r >= s2_hi_y_r);
    rev_y = (s2_dy_r > s2_sy_r);
    rev_x = (s2_dy_r == s2_sy_r) && (s2_dx_r > s2_sx_r);
    c0    = rev_x ? (s2_hi_x_r - SW'(1)) : s2_lo_x_r;
    r0    = rev_y ? (s2_hi_y_r - SW'(1)) : s2_lo_y_r;

    push_cmd         = '0;
    push_cmd.op      = s2_op_r;
    push_cmd.src_val = s2_fv_r;
    push_cmd.rfunc   = s2_rf_r;
    push_cmd.wmask   = s2_wmask_r;
    push_cmd.dmask   = dmask;
    push_cmd.ncols   = CW'(s2_hi_x_r - s2_lo_x_r);
    push_cmd.nrows   = CW'(s2_hi_y_r - s2_lo_y_r);
    case (s2_op_r)
      rob_pkg::OP_COPY: begin
        push_cmd.rev_x = rev_x;
        push_cmd.rev_y = rev_y;
        push_cmd.dst_x = CW'(s2_dx_r + c0);
        push_cmd.dst_y = CW'(s2_dy_r + r0);
        push_cmd.src_x = CW'(s2_sx_r + c0);
        push_cmd.src_y = CW'(s2_sy_r + r0);
      end
      rob_pkg::OP_READ: begin
        push_cmd.rd_zero = !s2_in_rng_r;
        push_cmd.dst_x   = CW'(s2_dx_r);
        push_cmd.dst_y   = CW'(s2_dy_r);
      end
      default: begin
        push_cmd.dst_x = CW'(s2_lo_x_r);
        push_cmd.dst_y = CW'(s2_lo_y_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= in_opcode;
      s1_sx_r <= in_src_x;
      s1_sy_r <= in_src_y;
      s1_dx_r <= in_dst_x;
      s1_dy_r <= in_dst_y;
      s1_aw_r <= in_area_width;
      s1_ah_r <= in_area_height;
      s1_fv_r <= in_fill_value;
      s1_rf_r <= in_raster_function;
      s1_pm_r <= in_plane_mask;
    end
    if (s2_load) begin
      s2_op_r     <= s1_op_r;
      s2_sx_r     <= sx_e;
      s2_sy_r     <= sy_e;
      s2_dx_r     <= dx_e;
      s2_dy_r     <= dy_e;
      s2_lo_x_r   <= lo_x;
      s2_lo_y_r   <= lo_y;
      s2_hi_x_r   <= hi_x;
      s2_hi_y_r   <= hi_y;
      s2_in_rng_r <= in_rng;
      s2_fv_r     <= s1_fv_r;
      s2_rf_r     <= s1_rf_r;
      s2_wmask_r  <= s1_pm_r & dmask;
    end
  end

endmodule

>>> design/rob_fifo.sv
// ----------------------------------------------------------------------------
// rob_fifo: command queue
// Short queue of clipped commands between the intake and the pixel engine.
// ----------------------------------------------------------------------------
module rob_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rob_pkg::cmd_t push_cmd,
  input  logic          pop,
  output rob_pkg::cmd_t head_cmd,
  output logic          full,
  output logic          empty
);

  localparam int DEPTH = rob_pkg::FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rob_pkg::cmd_t    q_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/rob_back.sv
// ----------------------------------------------------------------------------
// rob_back: pixel engine
// Owns the frame store: clears it after reset, then runs queued commands one
// pixel at a time as read-modify-write, and returns read results.
// ----------------------------------------------------------------------------
module rob_back #(
  parameter int MAX_WIDTH  = rob_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rob_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rob_pkg::COORD_W-1:0]   eff_w,
  input  logic                          fifo_empty,
  input  rob_pkg::cmd_t                 head_cmd,
  output logic                          pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_read_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ADW   = rob_pkg::ADDR_W;
  localparam int CW    = rob_pkg::COORD_W;
  localparam int PW    = rob_pkg::PIX_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SETUP = 7'b0000100,
    S_ISRC  = 7'b0001000,
    S_IDST  = 7'b0010000,
    S_WR    = 7'b0100000,
    S_RDONE = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  rob_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [ADW-1:0]  dst_row_r, dst_row_nxt, src_row_r, src_row_nxt;
  logic [ADW-1:0]  dst_cur_r, dst_cur_nxt, src_cur_r, src_cur_nxt;
  logic [CW-1:0]   col_cnt_r, col_cnt_nxt, row_cnt_r, row_cnt_nxt;
  logic [PW-1:0]   src_pix_r, src_pix_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [PW-1:0]   out_data_r, out_data_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;

  logic [PW-1:0]   mem [DEPTH];
  logic [PW-1:0]   rdata_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [PW-1:0]   mem_wdata;

  logic [PW-1:0]   rop_res;
  logic [ADW-1:0]  w_ext, dst_base, src_base, dst_row_step, src_row_step;

  assign clearing      = (state_r == S_CLEAR);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  assign w_ext    = ADW'(eff_w);
  assign dst_base = ADW'(cmd_r.dst_y) * w_ext + ADW'(cmd_r.dst_x);
  assign src_base = ADW'(cmd_r.src_y) * w_ext + ADW'(cmd_r.src_x);
  assign dst_row_step = cmd_r.rev_y ? (dst_row_r - w_ext) : (dst_row_r + w_ext);
  assign src_row_step = cmd_r.rev_y ? (src_row_r - w_ext) : (src_row_r + w_ext);
  assign rop_res  = rob_pkg::rop_apply(cmd_r.rfunc, src_pix_r, rdata_r);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    dst_row_nxt   = dst_row_r;
    src_row_nxt   = src_row_r;
    dst_cur_nxt   = dst_cur_r;
    src_cur_nxt   = src_cur_r;
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    src_pix_nxt   = src_pix_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    clr_addr_nxt  = clr_addr_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = dst_cur_r[AW-1:0];
    mem_raddr     = dst_cur_r[AW-1:0];
    mem_wdata     = ((rop_res & cmd_r.wmask) | (rdata_r & ~cmd_r.wmask)) & cmd_r.dmask;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!fifo_empty) begin
          pop       = 1'b1;
          cmd_nxt   = head_cmd;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        dst_row_nxt = dst_base;
        dst_cur_nxt = dst_base;
        src_row_nxt = src_base;
        src_cur_nxt = src_base;
        col_cnt_nxt = cmd_r.ncols;
        row_cnt_nxt = cmd_r.nrows;
        src_pix_nxt = cmd_r.src_val;
        state_nxt   = (cmd_r.op == rob_pkg::OP_COPY) ? S_ISRC : S_IDST;
      end
      S_ISRC: begin
        mem_re    = 1'b1;
        mem_raddr = src_cur_r[AW-1:0];
        state_nxt = S_IDST;
      end
      S_IDST: begin
        if (cmd_r.op == rob_pkg::OP_COPY) begin
          src_pix_nxt = rdata_r;
        end
        mem_re = !cmd_r.rd_zero;
        state_nxt = (cmd_r.op == rob_pkg::OP_READ) ? S_RDONE : S_WR;
      end
      S_WR: begin
        mem_we = 1'b1;
        if (col_cnt_r == CW'(1)) begin
          if (row_cnt_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            row_cnt_nxt = row_cnt_r - CW'(1);
            col_cnt_nxt = cmd_r.ncols;
            dst_row_nxt = dst_row_step;
            dst_cur_nxt = dst_row_step;
            src_row_nxt = src_row_step;
            src_cur_nxt = src_row_step;
            state_nxt   = (cmd_r.op == rob_pkg::OP_COPY) ? S_ISRC : S_IDST;
          end
        end else begin
          col_cnt_nxt = col_cnt_r - CW'(1);
          dst_cur_nxt = cmd_r.rev_x ? (dst_cur_r - ADW'(1)) : (dst_cur_r + ADW'(1));
          src_cur_nxt = cmd_r.rev_x ? (src_cur_r - ADW'(1)) : (src_cur_r + ADW'(1));
          state_nxt   = (cmd_r.op == rob_pkg::OP_COPY) ? S_ISRC : S_IDST;
        end
      end
      S_RDONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = cmd_r.rd_zero ? '0 : rdata_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    dst_row_r  <= dst_row_nxt;
    src_row_r  <= src_row_nxt;
    dst_cur_r  <= dst_cur_nxt;
    src_cur_r  <= src_cur_nxt;
    col_cnt_r  <= col_cnt_nxt;
    row_cnt_r  <= row_cnt_nxt;
    src_pix_r  <= src_pix_nxt;
    out_data_r <= out_data_nxt;
  end

  // frame store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !pop)
    else $error("command popped during store clear");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RDONE))
    else $error("result raised outside read completion");

  a_wr_counts_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (col_cnt_r != '0) && (row_cnt_r != '0))
    else $error("pixel write with exhausted counters");
`endif

endmodule
